// ===== hdl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define TKS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check on every clock edge, reset included.
`define TKS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== hdl/tksel_pkg.sv =====
package tksel_pkg;

  localparam int KEEP_W    = 5;
  localparam int TERM_W    = 17;
  localparam int FAC_W     = 24;
  localparam int SUM_W     = 40;
  localparam int MSB_W     = 6;
  localparam int L2_W      = 21;
  localparam int LN_W      = 13;
  localparam int LP_W      = 17;
  localparam int FRAC_BITS = 16;

  localparam logic [SUM_W-1:0] SUM_LIMIT = 40'hFF_FFFF_FFFF;
  localparam logic [31:0]      E1_Q31    = 32'd2139111403;
  localparam logic [15:0]      LN2_Q16   = 16'd45426;
  localparam logic [LP_W-1:0]  LP_FLOOR  = 17'h10000;

  // Control that travels with one item down the pipeline
  typedef struct packed {
    logic valid;
    logic last;
    logic resc;
  } item_ctl_t;

  // exp(-2^i/256) in Q0.31, by repeated rounded squaring of exp(-1/256)
  function automatic logic [31:0] exp_pow(input int i);
    logic [63:0] p;
    p = {32'd0, E1_Q31};
    for (int j = 0; j < i; j++) begin
      p = ((p * p) + 64'h4000_0000) >> 31;
    end
    return p[31:0];
  endfunction

endpackage

// ===== hdl/tksel_topk.sv =====
module tksel_topk #(
  parameter int K_MAX     = 16,
  parameter int VOCAB_MAX = 262144,
  parameter int LB        = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   adv,
  input  logic                                   in_valid,
  input  logic signed [LB-1:0]                   logit,
  input  logic                                   row_last,
  input  logic [tksel_pkg::KEEP_W-1:0]           keep_count,
  output tksel_pkg::item_ctl_t                   ctl_o,
  output logic [LB-1:0]                          d_res_o,
  output logic [LB-1:0]                          d_term_o,
  output logic signed [LB-1:0]                   max_o,
  output logic                                   snap_we,
  output logic [K_MAX-1:0][LB-1:0]               snap_vals,
  output logic [K_MAX-1:0][$clog2(VOCAB_MAX)-1:0] snap_ids,
  output logic [$clog2(K_MAX+1)-1:0]             snap_n,
  output logic                                   snap_ov
);
  import tksel_pkg::*;

  localparam int IDW = $clog2(VOCAB_MAX);
  localparam int NW  = $clog2(K_MAX + 1);
  localparam int KW  = (NW > KEEP_W) ? NW : KEEP_W;
  localparam int IW  = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam logic signed [LB-1:0] MOST_NEG = {1'b1, {(LB-1){1'b0}}};

  logic [K_MAX-1:0][LB-1:0]  vals_r, vals_nxt, vals_sh;
  logic [K_MAX-1:0][IDW-1:0] ids_r, ids_nxt, ids_sh;
  logic [NW-1:0]             held_r, held_nxt, k, cnt, k_m1;
  logic [IDW-1:0]            pos_r, pos_nxt;
  logic                      taken_r, taken_nxt, ov_r, ov_nxt;
  logic signed [LB-1:0]      max_r, max_nxt, weakest;
  logic [KW-1:0]             kc, keff;
  logic [IW-1:0]             kidx;
  logic [K_MAX:0]            ge_ext;
  logic                      fire, held_lt, ins, resc;
  logic signed [LB:0]        dr, dt;
  tksel_pkg::item_ctl_t      ctl_r;
  logic [LB-1:0]             d_res_r, d_term_r;
  logic signed [LB-1:0]      max_out_r;

  assign fire = adv && in_valid;

  // Clamp the configured count into 1..K_MAX
  always_comb begin
    kc = KW'(keep_count);
    if (kc == '0) begin
      keff = KW'(1);
    end else if (kc > KW'(K_MAX)) begin
      keff = KW'(K_MAX);
    end else begin
      keff = kc;
    end
  end

  assign k       = keff[NW-1:0];
  assign k_m1    = k - NW'(1);
  assign kidx    = k_m1[IW-1:0];
  assign weakest = $signed(vals_r[kidx]);
  assign held_lt = held_r < k;
  assign ins     = held_lt || (logit > weakest);
  assign cnt     = held_lt ? held_r : k_m1;

  // Sorted insertion: each lane keeps, takes the new pair or takes its upper neighbor
  always_comb begin
    ge_ext[0] = 1'b1;
    vals_sh[0] = vals_r[0];
    ids_sh[0]  = ids_r[0];
    for (int j = 0; j < K_MAX; j++) begin
      ge_ext[j+1] = (NW'(j) < cnt) && ($signed(vals_r[j]) >= logit);
    end
    for (int j = 1; j < K_MAX; j++) begin
      vals_sh[j] = vals_r[j-1];
      ids_sh[j]  = ids_r[j-1];
    end
    for (int j = 0; j < K_MAX; j++) begin
      vals_nxt[j] = vals_r[j];
      ids_nxt[j]  = ids_r[j];
      if (ins && (NW'(j) <= cnt) && !ge_ext[j+1]) begin
        if (ge_ext[j]) begin
          vals_nxt[j] = logit;
          ids_nxt[j]  = pos_r;
        end else begin
          vals_nxt[j] = vals_sh[j];
          ids_nxt[j]  = ids_sh[j];
        end
      end
    end
    held_nxt = ins ? (cnt + NW'(1)) : held_r;
  end

  // Token id counter, saturating at the top of the id range
  always_comb begin
    pos_nxt   = pos_r;
    taken_nxt = taken_r;
    ov_nxt    = ov_r;
    if (pos_r < IDW'(VOCAB_MAX - 1)) begin
      pos_nxt = pos_r + IDW'(1);
    end else if (!taken_r) begin
      taken_nxt = 1'b1;
    end else begin
      ov_nxt = 1'b1;
    end
  end

  // Running max and the two exponent distances
  always_comb begin
    resc    = logit > max_r;
    max_nxt = resc ? logit : max_r;
    dr      = {logit[LB-1], logit} - {max_r[LB-1], max_r};
    dt      = {max_nxt[LB-1], max_nxt} - {logit[LB-1], logit};
  end

  // Row state, cleared after the row's last item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= '0;
      pos_r   <= '0;
      taken_r <= 1'b0;
      ov_r    <= 1'b0;
      max_r   <= MOST_NEG;
    end else if (fire) begin
      if (row_last) begin
        held_r  <= '0;
        pos_r   <= '0;
        taken_r <= 1'b0;
        ov_r    <= 1'b0;
        max_r   <= MOST_NEG;
      end else begin
        held_r  <= held_nxt;
        pos_r   <= pos_nxt;
        taken_r <= taken_nxt;
        ov_r    <= ov_nxt;
        max_r   <= max_nxt;
      end
    end
  end

  // Survivor lanes
  always_ff @(posedge clk) begin
    if (fire) begin
      vals_r <= vals_nxt;
      ids_r  <= ids_nxt;
    end
  end

  // Hand the item to the exponent pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r.valid <= fire;
      ctl_r.last  <= row_last;
      ctl_r.resc  <= resc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_res_r   <= dr[LB-1:0];
      d_term_r  <= dt[LB-1:0];
      max_out_r <= max_nxt;
    end
  end

  assign ctl_o    = ctl_r;
  assign d_res_o  = d_res_r;
  assign d_term_o = d_term_r;
  assign max_o    = max_out_r;

  // Snapshot of the row at its last item
  assign snap_we   = fire && row_last;
  assign snap_vals = vals_nxt;
  assign snap_ids  = ids_nxt;
  assign snap_n    = (held_nxt < k) ? held_nxt : k;
  assign snap_ov   = ov_nxt;

endmodule

// ===== hdl/tksel_exp.sv =====
module tksel_exp #(
  parameter int LB = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  tksel_pkg::item_ctl_t               ctl_i,
  input  logic [LB-1:0]                      d_res_i,
  input  logic [LB-1:0]                      d_term_i,
  input  logic signed [LB-1:0]               max_i,
  output tksel_pkg::item_ctl_t               ctl_o,
  output logic [tksel_pkg::FAC_W-1:0]        fac_o,
  output logic [tksel_pkg::TERM_W-1:0]       term_o,
  output logic signed [LB-1:0]               max_o
);
  import tksel_pkg::*;

  item_ctl_t            st_ctl  [LB+1];
  logic [31:0]          st_rres [LB+1];
  logic [31:0]          st_rterm[LB+1];
  logic [LB-1:0]        st_dres [LB+1];
  logic [LB-1:0]        st_dterm[LB+1];
  logic signed [LB-1:0] st_max  [LB+1];
  logic [32:0]          fac_sum, term_sum;

  assign st_ctl[0]   = ctl_i;
  assign st_rres[0]  = 32'h8000_0000;
  assign st_rterm[0] = 32'h8000_0000;
  assign st_dres[0]  = d_res_i;
  assign st_dterm[0] = d_term_i;
  assign st_max[0]   = max_i;

  // One stage per distance bit: multiply by exp(-2^i/256) where the bit is set
  for (genvar i = 0; i < LB; i++) begin : g_stage
    localparam logic [31:0] P = exp_pow(i);
    logic [63:0] pr_res, pr_term;

    assign pr_res  = ({32'd0, st_rres[i]} * {32'd0, P}) + 64'h4000_0000;
    assign pr_term = ({32'd0, st_rterm[i]} * {32'd0, P}) + 64'h4000_0000;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_ctl[i+1] <= '0;
      end else if (adv) begin
        st_ctl[i+1] <= st_ctl[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_rres[i+1]  <= st_dres[i][i]  ? pr_res[62:31]  : st_rres[i];
        st_rterm[i+1] <= st_dterm[i][i] ? pr_term[62:31] : st_rterm[i];
        st_dres[i+1]  <= st_dres[i];
        st_dterm[i+1] <= st_dterm[i];
        st_max[i+1]   <= st_max[i];
      end
    end
  end

  // Round into the Q0.23 rescale factor and the Q.16 term
  assign fac_sum  = {1'b0, st_rres[LB]} + 33'd128;
  assign term_sum = {1'b0, st_rterm[LB]} + 33'h4000;
  assign fac_o    = fac_sum[31:8];
  assign term_o   = term_sum[31:15];
  assign ctl_o    = st_ctl[LB];
  assign max_o    = st_max[LB];

endmodule

// ===== hdl/tksel_lse.sv =====
module tksel_lse #(
  parameter int LB = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  tksel_pkg::item_ctl_t            ctl_i,
  input  logic [tksel_pkg::FAC_W-1:0]     fac_i,
  input  logic [tksel_pkg::TERM_W-1:0]    term_i,
  input  logic signed [LB-1:0]            max_i,
  output logic                            valid_o,
  output logic signed [LB-1:0]            max_o,
  output logic [tksel_pkg::LN_W-1:0]      ln_o
);
  import tksel_pkg::*;

  logic [SUM_W-1:0]     sum_r, sum_sat;
  logic [43:0]          p_hi, p_lo;
  logic [63:0]          prod;
  logic [SUM_W:0]       base;
  logic [SUM_W+1:0]     tot;
  logic                 z_valid_r;
  logic [SUM_W-1:0]     z_sum_r;
  logic signed [LB-1:0] z_max_r;
  logic [MSB_W-1:0]     msb, m_msb_r, ip;
  logic                 m_valid_r;
  logic [SUM_W-1:0]     m_sum_r;
  logic signed [LB-1:0] m_max_r;
  logic [SUM_W+30:0]    ysh;
  logic                 sq_valid[FRAC_BITS+1];
  logic                 sq_small[FRAC_BITS+1];
  logic [31:0]          sq_y    [FRAC_BITS+1];
  logic [L2_W-1:0]      sq_l2   [FRAC_BITS+1];
  logic signed [LB-1:0] sq_max  [FRAC_BITS+1];
  logic [36:0]          ln_prod;
  logic                 o_valid_r;
  logic signed [LB-1:0] o_max_r;
  logic [LN_W-1:0]      o_ln_r;

  // Rescale the running sum on a new max, add the term, saturate
  always_comb begin
    p_hi = {4'd0, sum_r[39:20]} * {20'd0, fac_i};
    p_lo = {4'd0, sum_r[19:0]} * {20'd0, fac_i};
    prod = {p_hi, 20'd0} + {20'd0, p_lo} + 64'h40_0000;
    base = ctl_i.resc ? prod[63:23] : {1'b0, sum_r};
    tot  = {1'b0, base} + {{(SUM_W+2-TERM_W){1'b0}}, term_i};
    sum_sat = (tot > {2'b00, SUM_LIMIT}) ? SUM_LIMIT : tot[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r     <= '0;
      z_valid_r <= 1'b0;
    end else if (adv) begin
      z_valid_r <= ctl_i.valid && ctl_i.last;
      if (ctl_i.valid) begin
        sum_r <= ctl_i.last ? '0 : sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      z_sum_r <= sum_sat;
      z_max_r <= max_i;
    end
  end

  // Find the leading one of the row sum
  always_comb begin
    msb = '0;
    for (int i = 0; i < SUM_W; i++) begin
      if (z_sum_r[i]) begin
        msb = MSB_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (adv) begin
      m_valid_r <= z_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_msb_r <= msb;
      m_sum_r <= z_sum_r;
      m_max_r <= z_max_r;
    end
  end

  // Normalize to a Q1.31 mantissa, integer part of log2
  assign ysh = {m_sum_r, 31'd0} >> m_msb_r;
  assign ip  = m_msb_r - MSB_W'(FRAC_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_valid[0] <= 1'b0;
    end else if (adv) begin
      sq_valid[0] <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_small[0] <= m_msb_r < MSB_W'(FRAC_BITS);
      sq_y[0]     <= ysh[31:0];
      sq_l2[0]    <= {ip[4:0], 16'd0};
      sq_max[0]   <= m_max_r;
    end
  end

  // One fraction bit per stage by squaring the mantissa
  for (genvar j = 0; j < FRAC_BITS; j++) begin : g_sq
    logic [63:0] sq;
    assign sq = {32'd0, sq_y[j]} * {32'd0, sq_y[j]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_valid[j+1] <= 1'b0;
      end else if (adv) begin
        sq_valid[j+1] <= sq_valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_small[j+1] <= sq_small[j];
        sq_max[j+1]   <= sq_max[j];
        if (sq[63]) begin
          sq_y[j+1]  <= sq[63:32];
          sq_l2[j+1] <= sq_l2[j] | (L2_W'(1) << (FRAC_BITS - 1 - j));
        end else begin
          sq_y[j+1]  <= sq[62:31];
          sq_l2[j+1] <= sq_l2[j];
        end
      end
    end
  end

  // Scale log2 by ln2 into Q.8
  assign ln_prod = ({16'd0, sq_l2[FRAC_BITS]} * {21'd0, LN2_Q16}) + 37'h80_0000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (adv) begin
      o_valid_r <= sq_valid[FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_max_r <= sq_max[FRAC_BITS];
      o_ln_r  <= sq_small[FRAC_BITS] ? '0 : ln_prod[36:24];
    end
  end

  assign valid_o = o_valid_r;
  assign max_o   = o_max_r;
  assign ln_o    = o_ln_r;

endmodule

// ===== hdl/tksel_emit.sv =====
module tksel_emit #(
  parameter int K_MAX     = 16,
  parameter int VOCAB_MAX = 262144,
  parameter int LB        = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    snap_we,
  input  logic [K_MAX-1:0][LB-1:0]                snap_vals,
  input  logic [K_MAX-1:0][$clog2(VOCAB_MAX)-1:0] snap_ids,
  input  logic [$clog2(K_MAX+1)-1:0]              snap_n,
  input  logic                                    snap_ov,
  input  logic                                    row_valid,
  input  logic signed [LB-1:0]                    row_max,
  input  logic [tksel_pkg::LN_W-1:0]              row_ln,
  output logic                                    can_take,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [$clog2(VOCAB_MAX)-1:0]            out_token_id,
  output logic signed [tksel_pkg::LP_W-1:0]       out_log_prob,
  output logic                                    out_row_overflow,
  output logic                                    out_last_result
);
  import tksel_pkg::*;

  localparam int IDW = $clog2(VOCAB_MAX);
  localparam int NW  = $clog2(K_MAX + 1);
  localparam int QD  = 2 ** $clog2(LB + 40);
  localparam int QAW = $clog2(QD);
  localparam int QW  = K_MAX * (LB + IDW) + NW + 1;
  localparam int ZW  = ((LB > LN_W + 1) ? LB : LN_W + 1) + 1;
  localparam int DW  = (ZW + 1 > 18) ? ZW + 1 : 18;

  logic [QW-1:0]             mem [QD];
  logic [QW-1:0]             rd_data_r;
  logic [QAW-1:0]            wr_ptr_r, rd_ptr_r, rd_ptr_nxt;
  logic [K_MAX-1:0][LB-1:0]  q_vals, em_vals_r;
  logic [K_MAX-1:0][IDW-1:0] q_ids, em_ids_r;
  logic [NW-1:0]             q_n, em_cnt_r;
  logic                      q_ov, em_ov_r, em_busy_r, take, fire;
  logic signed [ZW-1:0]      em_logz_r, logz;
  logic signed [DW-1:0]      diff;
  logic signed [LP_W-1:0]    lp;
  logic                      out_valid_r, out_ov_r, out_last_r;
  logic [IDW-1:0]            out_id_r;
  logic signed [LP_W-1:0]    out_lp_r;

  // Row snapshot queue
  always_ff @(posedge clk) begin
    if (snap_we) begin
      mem[wr_ptr_r] <= {snap_vals, snap_ids, snap_n, snap_ov};
    end
    rd_data_r <= mem[rd_ptr_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (snap_we) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  assign {q_vals, q_ids, q_n, q_ov} = rd_data_r;

  // Emit one pair per cycle while the output register is free
  assign fire       = em_busy_r && (!out_valid_r || out_ready);
  assign can_take   = !em_busy_r || (fire && (em_cnt_r == NW'(1)));
  assign take       = row_valid && can_take;
  assign rd_ptr_nxt = take ? (rd_ptr_r + QAW'(1)) : rd_ptr_r;
  assign logz       = {{(ZW-LB){row_max[LB-1]}}, row_max} + ZW'(row_ln);

  // Log probability of the head pair, clamped to the Q9.8 range
  always_comb begin
    diff = {{(DW-LB){em_vals_r[0][LB-1]}}, em_vals_r[0]}
         - {{(DW-ZW){em_logz_r[ZW-1]}}, em_logz_r};
    if (diff < -(DW'(65536))) begin
      lp = LP_FLOOR;
    end else if (diff > DW'(0)) begin
      lp = '0;
    end else begin
      lp = diff[LP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_busy_r <= 1'b0;
    end else if (take) begin
      em_busy_r <= 1'b1;
    end else if (fire && (em_cnt_r == NW'(1))) begin
      em_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      em_vals_r <= q_vals;
      em_ids_r  <= q_ids;
      em_cnt_r  <= q_n;
      em_ov_r   <= q_ov;
      em_logz_r <= logz;
    end else if (fire) begin
      for (int j = 0; j < K_MAX - 1; j++) begin
        em_vals_r[j] <= em_vals_r[j+1];
        em_ids_r[j]  <= em_ids_r[j+1];
      end
      em_cnt_r <= em_cnt_r - NW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_id_r   <= em_ids_r[0];
      out_lp_r   <= lp;
      out_ov_r   <= em_ov_r;
      out_last_r <= em_cnt_r == NW'(1);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_token_id     = out_id_r;
  assign out_log_prob     = out_lp_r;
  assign out_row_overflow = out_ov_r;
  assign out_last_result  = out_last_r;

endmodule

// ===== hdl/topk_log_softmax_selector.sv =====
// Top-k selector with log-softmax over a streamed row of logits.
// Input channel: in_logit (Q8.8) and in_row_last, valid/ready. One logit per
// transaction; its token id is its position in the row. Results leave on the
// out_ channel, valid/ready, one (id, log prob) pair per transaction, best
// first, out_last_result on the row's final pair.
// cfg_we/cfg_data write the keep count at any edge with cfg_we high; write it
// only while the block is idle.
// Throughput: one logit per cycle, back to back, across rows, while in_ready
// stays high. A row's results follow its last logit through one input stage,
// one top-k stage, LOGIT_BITS exponent stages, then the sum, leading-one,
// normalize, 16 log squaring and scaling stages, and the emitter. Pairs then
// leave at one per cycle while out_ready is high.
// Finished row snapshots wait in a small queue. in_ready drops only while a
// finished row waits for the emitter, i.e. when the receiver stalls out_ready
// long enough to back up the pipeline; nothing is lost.
// Reset (rst_n low, synchronous) empties the pipeline, clears the row state
// and sets the keep count to 1.
module topk_log_softmax_selector #(
  parameter int K_MAX      = 16,
  parameter int VOCAB_MAX  = 262144,
  parameter int LOGIT_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [tksel_pkg::KEEP_W-1:0]          cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [LOGIT_BITS-1:0]          in_logit,
  input  logic                                  in_row_last,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [$clog2(VOCAB_MAX)-1:0]          out_token_id,
  output logic signed [tksel_pkg::LP_W-1:0]     out_log_prob,
  output logic                                  out_row_overflow,
  output logic                                  out_last_result
);
  import tksel_pkg::*;

  `include "assert_macros.svh"

  localparam int LB  = LOGIT_BITS;
  localparam int IDW = $clog2(VOCAB_MAX);
  localparam int NW  = $clog2(K_MAX + 1);

  logic [KEEP_W-1:0]         keep_count_r;
  logic                      s0_valid_r, s0_last_r;
  logic signed [LB-1:0]      s0_logit_r;
  logic                      adv, can_take, row_valid;
  item_ctl_t                 a_ctl, e_ctl;
  logic [LB-1:0]             a_dres, a_dterm;
  logic signed [LB-1:0]      a_max, e_max, row_max;
  logic [FAC_W-1:0]          e_fac;
  logic [TERM_W-1:0]         e_term;
  logic [LN_W-1:0]           row_ln;
  logic                      snap_we, snap_ov;
  logic [K_MAX-1:0][LB-1:0]  snap_vals;
  logic [K_MAX-1:0][IDW-1:0] snap_ids;
  logic [NW-1:0]             snap_n;

  // Advance the whole pipeline unless a finished row waits for the emitter
  assign adv      = !row_valid || can_take;
  assign in_ready = adv;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_count_r <= KEEP_W'(1);
    end else if (cfg_we) begin
      keep_count_r <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (adv) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_logit_r <= in_logit;
      s0_last_r  <= in_row_last;
    end
  end

  tksel_topk #(.K_MAX(K_MAX), .VOCAB_MAX(VOCAB_MAX), .LB(LB)) u_topk (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (s0_valid_r),
    .logit      (s0_logit_r),
    .row_last   (s0_last_r),
    .keep_count (keep_count_r),
    .ctl_o      (a_ctl),
    .d_res_o    (a_dres),
    .d_term_o   (a_dterm),
    .max_o      (a_max),
    .snap_we    (snap_we),
    .snap_vals  (snap_vals),
    .snap_ids   (snap_ids),
    .snap_n     (snap_n),
    .snap_ov    (snap_ov)
  );

  tksel_exp #(.LB(LB)) u_exp (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .ctl_i    (a_ctl),
    .d_res_i  (a_dres),
    .d_term_i (a_dterm),
    .max_i    (a_max),
    .ctl_o    (e_ctl),
    .fac_o    (e_fac),
    .term_o   (e_term),
    .max_o    (e_max)
  );

  tksel_lse #(.LB(LB)) u_lse (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .ctl_i   (e_ctl),
    .fac_i   (e_fac),
    .term_i  (e_term),
    .max_i   (e_max),
    .valid_o (row_valid),
    .max_o   (row_max),
    .ln_o    (row_ln)
  );

  tksel_emit #(.K_MAX(K_MAX), .VOCAB_MAX(VOCAB_MAX), .LB(LB)) u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .snap_we          (snap_we),
    .snap_vals        (snap_vals),
    .snap_ids         (snap_ids),
    .snap_n           (snap_n),
    .snap_ov          (snap_ov),
    .row_valid        (row_valid),
    .row_max          (row_max),
    .row_ln           (row_ln),
    .can_take         (can_take),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_id     (out_token_id),
    .out_log_prob     (out_log_prob),
    .out_row_overflow (out_row_overflow),
    .out_last_result  (out_last_result)
  );

  `TKS_ASSERT(a_stall_only_on_row, !in_ready |-> row_valid, "input stalled with no row waiting")
  `TKS_ASSERT(a_lp_not_positive, out_valid |-> out_log_prob <= 0, "positive log probability")
  `TKS_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "result valid after reset")

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tksel_pkg::*;

  localparam int KMAX      = 16;
  localparam int VOCAB     = 262144;
  localparam int ID_W      = 18;
  localparam int LATENCY   = 60;
  localparam int IDLE_LIMIT = 2000;

  typedef struct {
    logic [ID_W-1:0] id;
    logic [LP_W-1:0] lp;
    logic            ovf;
    logic            last;
  } pick_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [KEEP_W-1:0]     cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic signed [15:0]    in_logit;
  logic                  in_row_last;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ID_W-1:0]       out_token_id;
  logic signed [LP_W-1:0] out_log_prob;
  logic                  out_row_overflow;
  logic                  out_last_result;

  topk_log_softmax_selector u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_logit         (in_logit),
    .in_row_last      (in_row_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_id     (out_token_id),
    .out_log_prob     (out_log_prob),
    .out_row_overflow (out_row_overflow),
    .out_last_result  (out_last_result)
  );

  // Predictor state
  int                 top_vals [KMAX];
  logic [ID_W-1:0]    top_ids  [KMAX];
  int unsigned        held;
  int unsigned        row_pos;
  bit                 last_id_given;
  int                 row_max;
  longint unsigned    exp_acc;
  bit                 row_ovf;
  int unsigned        keep;
  pick_t              picks_q[$];

  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_len = 0;
  int  hold_req = 0;
  int  hold_ack = 0;
  int  hold_off = 0;
  int  mismatches = 0;

  // exp(-d/256) in Q0.31
  function automatic longint unsigned exp_neg(longint unsigned d);
    longint unsigned r;
    longint unsigned p;
    r = 64'd1 << 31;
    p = 64'd2139111403;
    while (d != 0 && r != 0) begin
      if (d[0]) r = (r * p + (64'd1 << 30)) >> 31;
      p = (p * p + (64'd1 << 30)) >> 31;
      d = d >> 1;
    end
    return r;
  endfunction

  // ln(s / 2^16) in Q.8
  function automatic longint ln_q8(longint unsigned s);
    int msb;
    longint unsigned y;
    longint unsigned l2;
    msb = 0;
    for (int i = 0; i < 64; i++) if (s[i]) msb = i;
    if (msb < 16) return 0;
    y = (msb >= 31) ? (s >> (msb - 31)) : (s << (31 - msb));
    l2 = longint'(msb - 16) << 16;
    for (int i = 15; i >= 0; i--) begin
      y = (y * y) >> 31;
      if (y >= (64'd1 << 32)) begin
        y = y >> 1;
        l2 = l2 | (64'd1 << i);
      end
    end
    return longint'((l2 * 64'd45426 + (64'd1 << 23)) >> 24);
  endfunction

  task automatic clear_row();
    held = 0;
    row_pos = 0;
    last_id_given = 0;
    row_max = -32768;
    exp_acc = 0;
    row_ovf = 0;
  endtask

  // Advance the predictor by one accepted logit
  task automatic predict_topk(logic signed [15:0] logit, logic last);
    int x;
    logic [ID_W-1:0] id;
    int unsigned k, cnt, at, n;
    longint unsigned f;
    longint logz, lp;
    pick_t p;
    x = int'(logit);
    id = ID_W'(row_pos);
    if (row_pos < VOCAB - 1) row_pos++;
    else if (!last_id_given) last_id_given = 1;
    else row_ovf = 1;

    k = (keep < 1) ? 1 : ((keep > KMAX) ? KMAX : keep);
    if (held < k || x > top_vals[k-1]) begin
      cnt = (held < k) ? held : k - 1;
      at = 0;
      while (at < cnt && top_vals[at] >= x) at++;
      for (int j = cnt; j > at; j--) begin
        top_vals[j] = top_vals[j-1];
        top_ids[j]  = top_ids[j-1];
      end
      top_vals[at] = x;
      top_ids[at]  = id;
      held = cnt + 1;
    end

    if (x > row_max) begin
      f = (exp_neg(longint'(x - row_max)) + 128) >> 8;
      exp_acc = (exp_acc * f + (64'd1 << 22)) >> 23;
      row_max = x;
    end
    exp_acc += (exp_neg(longint'(row_max - x)) + (64'd1 << 14)) >> 15;
    if (exp_acc > 64'hFF_FFFF_FFFF) exp_acc = 64'hFF_FFFF_FFFF;

    if (last) begin
      n = (held < k) ? held : k;
      logz = longint'(row_max) + ln_q8(exp_acc);
      for (int j = 0; j < n; j++) begin
        lp = longint'(top_vals[j]) - logz;
        if (lp < -65536) lp = -65536;
        if (lp > 0) lp = 0;
        p.id   = top_ids[j];
        p.lp   = lp[LP_W-1:0];
        p.ovf  = row_ovf;
        p.last = (j + 1 == n);
        picks_q.push_back(p);
      end
      clear_row();
    end
  endtask

  // Clock
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Drive out_ready: random stalls, or a counted hold-off
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_off  <= hold_len - 1;
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off  <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check each result transaction against the oldest prediction
  always @(posedge clk) begin
    pick_t p;
    if (rst_n && out_valid && out_ready) begin
      if (picks_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result id=%0d lp=%0d", out_token_id, out_log_prob);
      end else begin
        p = picks_q.pop_front();
        if (out_token_id !== p.id || out_log_prob !== p.lp ||
            out_row_overflow !== p.ovf || out_last_result !== p.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp id=%0d lp=%0d ovf=%0b last=%0b got id=%0d lp=%0d ovf=%0b last=%0b",
                     p.id, $signed(p.lp), p.ovf, p.last, out_token_id, out_log_prob,
                     out_row_overflow, out_last_result);
        end
      end
    end
  end

  // Watchdog: end the run after a long stretch with no transaction
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Send one logit transaction, with random idle cycles ahead of it
  task automatic send_logit(logic signed [15:0] logit, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_logit    <= logit;
    in_row_last <= last;
    do @(posedge clk); while (!in_ready);
    predict_topk(logit, last);
  endtask

  // Hold the input idle until all predicted results are out, then settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (picks_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic set_keep(int v);
    logic [KEEP_W-1:0] val;
    val = KEEP_W'(v);
    cfg_we   <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    keep = 32'(val);
  endtask

  function automatic logic signed [15:0] rand_logit();
    case ($urandom_range(3))
      0: return 16'(int'($urandom_range(8)) - 4);
      1: return 16'($urandom_range(1023) + 16'h0400);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_row(int len);
    for (int i = 0; i < len; i++) send_logit(rand_logit(), i == len - 1);
  endtask

  // Extremes, ties, short rows and log_prob saturation
  task automatic test_directed();
    send_logit(16'sh7FFF, 1'b0);
    send_logit(-16'sh8000, 1'b0);
    send_logit(16'sh0000, 1'b0);
    send_logit(16'sh0001, 1'b0);
    send_logit(-16'sh0001, 1'b1);
    drain();
    set_keep(16);
    send_logit(16'sh0100, 1'b0);
    send_logit(-16'sh0200, 1'b0);
    send_logit(16'sh0300, 1'b1);
    send_logit(16'sh0042, 1'b1);
    drain();
    set_keep(3);
    send_logit(16'sh0005, 1'b0);
    send_logit(16'sh0005, 1'b0);
    send_logit(16'sh0005, 1'b0);
    send_logit(16'sh0007, 1'b0);
    send_logit(16'sh0005, 1'b0);
    send_logit(16'sh0007, 1'b1);
    send_logit(-16'sh8000, 1'b0);
    send_logit(-16'sh8000, 1'b0);
    send_logit(16'sh7FFF, 1'b1);
    drain();
  endtask

  // Out-of-range keep counts clamp
  task automatic test_keep_clamp();
    set_keep(0);
    send_row(6);
    drain();
    set_keep(31);
    send_row(20);
    drain();
    set_keep(17);
    send_row(18);
    drain();
  endtask

  // Lower the keep count in the middle of a row
  task automatic test_keep_midrow();
    set_keep(8);
    for (int i = 0; i < 10; i++) send_logit(rand_logit(), 1'b0);
    drain();
    set_keep(2);
    send_row(5);
    drain();
  endtask

  // Random rows across idle/stall phases
  task automatic test_random();
    int idle_set[4]  = '{0, 46, 0, 7};
    int stall_set[4] = '{0, 0, 46, 7};
    int keep_set[4]  = '{16, 1, 5, 12};
    int sent;
    int len;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_set[ph];
      recv_stall_pct = stall_set[ph];
      set_keep(keep_set[ph]);
      sent = 0;
      while (sent < 10) begin
        len = ($urandom_range(4) == 0) ? $urandom_range(24, 1) : $urandom_range(8, 1);
        send_row(len);
        sent += len;
      end
      drain();
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // Stall the receiver long enough to back up the input
  task automatic test_backpressure();
    set_keep(16);
    hold_len = 300;
    hold_req++;
    for (int r = 0; r < 15; r++) send_row(2);
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_logit = '0;
    in_row_last = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    keep = 1;
    for (int i = 0; i < KMAX; i++) begin
      top_vals[i] = 0;
      top_ids[i] = '0;
    end
    clear_row();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_keep_clamp();
    test_keep_midrow();
    test_random();
    test_backpressure();

    if (mismatches == 0 && picks_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
